/* src/spi_nor_flash_command_sequencer_unit_defines.svh */
// assertion macros for the spi nor flash command sequencer
// used by the port checker
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_DEFINES_SVH

`define SNF_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define SNF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/snfcs_pkg.sv */
// package for the spi nor flash command sequencer
// types, codes and result record; no dependencies
`default_nettype none
package snfcs_pkg;

  localparam int unsigned IN_W  = 51;
  localparam int unsigned OUT_W = 48;

  typedef enum logic [2:0] {
    ACT_READ  = 3'd0,
    ACT_PROG  = 3'd1,
    ACT_ERASE = 3'd2,
    ACT_CHIP  = 3'd3,
    ACT_ID    = 3'd4,
    ACT_HOST  = 3'd5,
    ACT_RESP  = 3'd6,
    ACT_BAD   = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    K_SPI  = 3'd0,
    K_HOST = 3'd1,
    K_WANT = 3'd2,
    K_DONE = 3'd3,
    K_REJ  = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_RD_HDR, PH_RD_DATA, PH_WREN, PH_PP_HDR, PH_PP_WANT, PH_PP_DATA,
    PH_POLL_CMD, PH_POLL_STAT, PH_SE_HDR, PH_CE_CMD, PH_ID, PH_PRE_CMD, PH_PRE_STAT
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_READ, OP_PROG, OP_ERASE, OP_CHIP, OP_ID
  } op_t;

  localparam logic [7:0] CMD_READ = 8'h03;
  localparam logic [7:0] CMD_PP   = 8'h02;
  localparam logic [7:0] CMD_WREN = 8'h06;
  localparam logic [7:0] CMD_RDSR = 8'h05;
  localparam logic [7:0] CMD_SE   = 8'h20;
  localparam logic [7:0] CMD_CE   = 8'hC7;
  localparam logic [7:0] CMD_RDID = 8'h9F;
  localparam logic [7:0] DUMMY    = 8'hFF;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  spi_byte;
    logic        hold_select;
    logic [7:0]  host_byte;
    logic [23:0] id_value;
  } res_t;

  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } step_t;

  function automatic res_t mk(kind_t k, logic [7:0] s, logic h, logic [7:0] hb,
                              logic [23:0] id);
    res_t r;
    r.kind = k; r.spi_byte = s; r.hold_select = h; r.host_byte = hb; r.id_value = id;
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/snfcs_core.sv */
// sequencer state and single-pass next-state logic
// depends on snfcs_pkg
`default_nettype none
module snfcs_core #(
  parameter int unsigned PAGE_BYTES   = 256,
  parameter int unsigned SECTOR_BYTES = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire logic [2:0]           action,
  input  wire logic [23:0]          address,
  input  wire logic [15:0]          length,
  input  wire logic [7:0]           data_byte,
  output snfcs_pkg::step_t          step
);
  import snfcs_pkg::*;

  localparam int unsigned PW = $clog2(PAGE_BYTES);
  localparam int unsigned SW = $clog2(SECTOR_BYTES);

  phase_t      phase, phase_next;
  logic [2:0]  fbi, fbi_next;
  logic [23:0] cur, cur_next;
  logic [8:0]  chunk, chunk_next;
  logic [15:0] total, total_next;
  logic [15:0] sect, sect_next;
  op_t         op, op_next;
  logic [23:0] ids, ids_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; fbi <= '0; cur <= '0; chunk <= '0;
      total <= '0; sect <= '0; op <= OP_NONE; ids <= '0;
    end else if (go) begin
      phase <= phase_next; fbi <= fbi_next; cur <= cur_next; chunk <= chunk_next;
      total <= total_next; sect <= sect_next; op <= op_next; ids <= ids_next;
    end
  end

  function automatic logic [7:0] abyte(logic [2:0] i, logic [23:0] a);
    logic [7:0] b;
    case (i)
      3'd1:    b = a[23:16];
      3'd2:    b = a[15:8];
      default: b = a[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [8:0] room_of(logic [23:0] a, logic [15:0] t);
    logic [9:0] rm;
    rm = 10'(PAGE_BYTES) - 10'(a[PW-1:0]);
    return ({6'd0, rm} > t) ? t[8:0] : rm[8:0];
  endfunction

  always_comb begin
    res_t r0, r1, rej, spi_o;
    logic two;
    logic idle;
    logic [2:0] i;
    logic [23:0] sa;
    phase_next = phase; fbi_next = fbi; cur_next = cur; chunk_next = chunk;
    total_next = total; sect_next = sect; op_next = op; ids_next = ids;
    rej = mk(K_REJ, 8'd0, 1'b0, 8'd0, 24'd0);
    spi_o = rej;
    r0 = rej; r1 = rej; two = 1'b0;
    i = fbi;
    idle = (phase == PH_IDLE) || (phase > PH_PRE_STAT);
    sa = address;
    sa[SW-1:0] = '0;
    case (action_t'(action))
      ACT_READ, ACT_PROG, ACT_ERASE, ACT_CHIP, ACT_ID: begin
        if (idle) begin
          fbi_next = '0;
          cur_next = address;
          case (action_t'(action))
            ACT_READ: begin
              op_next = OP_READ; total_next = length; phase_next = PH_RD_HDR;
              fbi_next = 3'd1; r0 = mk(K_SPI, CMD_READ, 1'b1, 8'd0, 24'd0);
            end
            ACT_PROG: begin
              op_next = OP_PROG; total_next = length;
              if (length == 16'd0) begin
                phase_next = PH_IDLE; op_next = OP_NONE;
                r0 = mk(K_DONE, 8'd0, 1'b0, 8'd0, 24'd0);
              end else begin
                chunk_next = room_of(address, length); phase_next = PH_WREN;
                r0 = mk(K_SPI, CMD_WREN, 1'b0, 8'd0, 24'd0);
              end
            end
            ACT_ERASE: begin
              op_next = OP_ERASE; sect_next = length; cur_next = sa;
              if (length == 16'd0) begin
                phase_next = PH_IDLE; op_next = OP_NONE;
                r0 = mk(K_DONE, 8'd0, 1'b0, 8'd0, 24'd0);
              end else begin
                phase_next = PH_WREN;
                r0 = mk(K_SPI, CMD_WREN, 1'b0, 8'd0, 24'd0);
              end
            end
            ACT_CHIP: begin
              op_next = OP_CHIP; phase_next = PH_WREN;
              r0 = mk(K_SPI, CMD_WREN, 1'b0, 8'd0, 24'd0);
            end
            default: begin
              op_next = OP_ID; ids_next = '0; phase_next = PH_ID; fbi_next = 3'd1;
              r0 = mk(K_SPI, CMD_RDID, 1'b1, 8'd0, 24'd0);
            end
          endcase
        end
      end
      ACT_HOST: begin
        if (phase == PH_PP_WANT) begin
          r0 = mk(K_SPI, data_byte, chunk > 9'd1, 8'd0, 24'd0);
          chunk_next = chunk - 9'd1; total_next = total - 16'd1;
          cur_next = cur + 24'd1; phase_next = PH_PP_DATA;
        end
      end
      ACT_RESP: begin
        if (!idle && phase != PH_PP_WANT) begin
          case (phase)
            PH_RD_HDR: begin
              if (fbi < 3'd4) begin
                fbi_next = fbi + 3'd1;
                r0 = mk(K_SPI, abyte(i, cur), (i < 3'd3) ? 1'b1 : (total != 16'd0),
                        8'd0, 24'd0);
              end else if (total == 16'd0) begin
                phase_next = PH_IDLE; op_next = OP_NONE; fbi_next = '0;
                r0 = mk(K_DONE, 8'd0, 1'b0, 8'd0, 24'd0);
              end else begin
                phase_next = PH_RD_DATA;
                r0 = mk(K_SPI, DUMMY, total > 16'd1, 8'd0, 24'd0);
              end
            end
            PH_RD_DATA: begin
              two = 1'b1;
              r0 = mk(K_HOST, 8'd0, 1'b0, data_byte, 24'd0);
              total_next = total - 16'd1; cur_next = cur + 24'd1;
              if (total_next != 16'd0) begin
                r1 = mk(K_SPI, DUMMY, total_next > 16'd1, 8'd0, 24'd0);
              end else begin
                phase_next = PH_IDLE; op_next = OP_NONE; fbi_next = '0;
                r1 = mk(K_DONE, 8'd0, 1'b0, 8'd0, 24'd0);
              end
            end
            PH_WREN: begin
              if (op == OP_PROG) begin
                phase_next = PH_PP_HDR; fbi_next = 3'd1;
                r0 = mk(K_SPI, CMD_PP, 1'b1, 8'd0, 24'd0);
              end else if (op == OP_ERASE) begin
                phase_next = PH_PRE_CMD;
                r0 = mk(K_SPI, CMD_RDSR, 1'b1, 8'd0, 24'd0);
              end else begin
                phase_next = PH_CE_CMD;
                r0 = mk(K_SPI, CMD_CE, 1'b0, 8'd0, 24'd0);
              end
            end
            PH_PP_HDR: begin
              if (fbi < 3'd4) begin
                fbi_next = fbi + 3'd1;
                r0 = mk(K_SPI, abyte(i, cur), 1'b1, 8'd0, 24'd0);
              end else begin
                phase_next = PH_PP_WANT;
                r0 = mk(K_WANT, 8'd0, 1'b0, 8'd0, 24'd0);
              end
            end
            PH_PP_DATA: begin
              if (chunk != 9'd0) begin
                phase_next = PH_PP_WANT;
                r0 = mk(K_WANT, 8'd0, 1'b0, 8'd0, 24'd0);
              end else begin
                phase_next = PH_POLL_CMD;
                r0 = mk(K_SPI, CMD_RDSR, 1'b1, 8'd0, 24'd0);
              end
            end
            PH_POLL_CMD: begin
              phase_next = PH_POLL_STAT;
              r0 = mk(K_SPI, DUMMY, 1'b0, 8'd0, 24'd0);
            end
            PH_POLL_STAT: begin
              if (data_byte[0]) begin
                phase_next = PH_POLL_CMD;
                r0 = mk(K_SPI, CMD_RDSR, 1'b1, 8'd0, 24'd0);
              end else begin
                r0 = mk(K_DONE, 8'd0, 1'b0, 8'd0, 24'd0);
                phase_next = PH_IDLE; op_next = OP_NONE; fbi_next = '0;
                if (op == OP_PROG && total != 16'd0) begin
                  chunk_next = room_of(cur, total); phase_next = PH_WREN;
                  op_next = op; fbi_next = fbi;
                  r0 = mk(K_SPI, CMD_WREN, 1'b0, 8'd0, 24'd0);
                end else if (op == OP_ERASE) begin
                  sect_next = sect - 16'd1;
                  cur_next = cur + 24'(SECTOR_BYTES);
                  if (sect_next != 16'd0) begin
                    phase_next = PH_WREN; op_next = op; fbi_next = fbi;
                    r0 = mk(K_SPI, CMD_WREN, 1'b0, 8'd0, 24'd0);
                  end
                end
              end
            end
            PH_PRE_CMD: begin
              phase_next = PH_PRE_STAT;
              r0 = mk(K_SPI, DUMMY, 1'b0, 8'd0, 24'd0);
            end
            PH_PRE_STAT: begin
              if (data_byte[0]) begin
                phase_next = PH_PRE_CMD;
                r0 = mk(K_SPI, CMD_RDSR, 1'b1, 8'd0, 24'd0);
              end else begin
                phase_next = PH_SE_HDR; fbi_next = 3'd1;
                r0 = mk(K_SPI, CMD_SE, 1'b1, 8'd0, 24'd0);
              end
            end
            PH_SE_HDR: begin
              if (fbi < 3'd4) begin
                fbi_next = fbi + 3'd1;
                r0 = mk(K_SPI, abyte(i, cur), i < 3'd3, 8'd0, 24'd0);
              end else begin
                phase_next = PH_POLL_CMD;
                r0 = mk(K_SPI, CMD_RDSR, 1'b1, 8'd0, 24'd0);
              end
            end
            PH_CE_CMD: begin
              phase_next = PH_POLL_CMD;
              r0 = mk(K_SPI, CMD_RDSR, 1'b1, 8'd0, 24'd0);
            end
            PH_ID: begin
              if (fbi >= 3'd2) ids_next = {ids[15:0], data_byte};
              if (fbi < 3'd4) begin
                fbi_next = fbi + 3'd1;
                r0 = mk(K_SPI, DUMMY, i < 3'd3, 8'd0, 24'd0);
              end else begin
                phase_next = PH_IDLE; op_next = OP_NONE; fbi_next = '0;
                r0 = mk(K_DONE, 8'd0, 1'b0, 8'd0, ids_next);
              end
            end
            default: r0 = rej;
          endcase
        end
      end
      default: r0 = rej;
    endcase
    step.r0 = r0;
    step.r1 = r1;
    step.two = two;
  end

endmodule
`default_nettype wire

/* src/snfcs_out.sv */
// result register: holds up to two results of one request and sends them in turn
// depends on snfcs_pkg
`default_nettype none
module snfcs_out (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  snfcs_pkg::step_t            step,
  output logic                        busy_next_free,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [snfcs_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast
);
  import snfcs_pkg::*;

  res_t       a, b;
  logic       va, vb;
  logic       pop;

  assign pop = m_axis_tvalid && m_axis_tready;
  // free when nothing remains after this cycle's pop
  assign busy_next_free = !va || (pop && !vb);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0;
    end else if (load) begin
      va <= 1'b1; vb <= step.two;
    end else if (pop) begin
      va <= vb; vb <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a <= step.r0; b <= step.r1;
    end else if (pop) begin
      a <= b;
    end
  end

  assign m_axis_tvalid = va;
  assign m_axis_tlast  = !vb;
  // kind, spi_byte, hold_select, host_byte, id_value, pad
  assign m_axis_tdata = {4'd0, a.id_value, a.host_byte, a.hold_select, a.spi_byte,
                         a.kind};

endmodule
`default_nettype wire

/* src/spi_nor_flash_command_sequencer_unit.sv */
// top level of the spi nor flash command sequencer
// depends on snfcs_pkg, snfcs_core, snfcs_out
// One request per clock while there is room: each request moves the sequencer
// one SPI byte along and yields one result, or two (host byte then next byte or
// done) while reading. A request is taken whenever the result register will be
// empty after this cycle, so a read holds the next request until both are sent.
`default_nettype none
module spi_nor_flash_command_sequencer_unit #(
  parameter int unsigned PAGE_BYTES   = 256,
  parameter int unsigned SECTOR_BYTES = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // action, address, length, data_byte, pad
  input  wire logic [55:0]                 s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // kind, spi_byte, hold_select, host_byte, id_value, pad
  output logic [snfcs_pkg::OUT_W-1:0]      m_axis_tdata,
  output logic                             m_axis_tlast
);
  import snfcs_pkg::*;

  step_t st;
  logic  go;
  logic  free;

  assign s_axis_tready = free;
  assign go = s_axis_tvalid && s_axis_tready;

  snfcs_core #(.PAGE_BYTES(PAGE_BYTES), .SECTOR_BYTES(SECTOR_BYTES)) u_core (
    .clk(clk), .rst(rst), .go(go),
    .action(s_axis_tdata[2:0]), .address(s_axis_tdata[26:3]),
    .length(s_axis_tdata[42:27]), .data_byte(s_axis_tdata[50:43]),
    .step(st)
  );

  snfcs_out u_out (
    .clk(clk), .rst(rst), .load(go), .step(st), .busy_next_free(free),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

endmodule
`default_nettype wire

/* src/snfcs_checker.sv */
// port checker for the spi nor flash command sequencer
// depends on the defines header and the top level
`default_nettype none
`include "spi_nor_flash_command_sequencer_unit_defines.svh"
module snfcs_port_props (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  `SNF_ASSERT_IMP(a_out_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
  `SNF_ASSERT(a_kind_range, !m_axis_tvalid || m_axis_tdata[2:0] <= 3'd4, "bad kind")
  `SNF_ASSERT_IMP(a_req_makes_result, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "request gave no result")
  `SNF_ASSERT(a_ready_needs_room, !(s_axis_tready && m_axis_tvalid && !m_axis_tlast), "request taken with results pending")
endmodule

bind spi_nor_flash_command_sequencer_unit snfcs_port_props u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
